### rtl/bbps_pkg.sv
// ----------------------------------------------------------------------------
// bbps_pkg
// Shared types and constants for the buzzer beep pattern sequencer.
// ----------------------------------------------------------------------------
package bbps_pkg;

    localparam int unsigned FREQ_W    = 16;
    localparam int unsigned TIME_W    = 16;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned TICK_W    = 10;
    localparam int unsigned ELAPSED_W = 18;

    localparam logic [TICK_W-1:0] TICK_PERIOD_RESET = TICK_W'(30);

    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SOUND = 2'd1,
        PH_GAP   = 2'd2
    } phase_t;

    typedef struct packed {
        logic               kind;
        logic [FREQ_W-1:0]  tone_freq;
        logic [TIME_W-1:0]  on_ms;
        logic [TIME_W-1:0]  off_ms;
        logic [COUNT_W-1:0] repeat_count;
    } item_t;

    typedef struct packed {
        logic              valid;
        logic [FREQ_W-1:0] tone;
    } result_t;

endpackage

### rtl/bbps_in_reg.sv
// ----------------------------------------------------------------------------
// bbps_in_reg
// Input register: holds one accepted request until the core takes it.
// ----------------------------------------------------------------------------
module bbps_in_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  bbps_pkg::item_t in_item,
    input  logic          take,
    output logic          item_valid,
    output bbps_pkg::item_t item
);
    import bbps_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload: load on accept only
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### rtl/bbps_core.sv
// ----------------------------------------------------------------------------
// bbps_core
// Pattern state and single-pass update for one command or tick.
// ----------------------------------------------------------------------------
module bbps_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  bbps_pkg::item_t               item,
    input  logic [bbps_pkg::TICK_W-1:0]   tick_period,
    output bbps_pkg::result_t             res
);
    import bbps_pkg::*;

    phase_t               phase_reg,   phase_next;
    logic                 pending_reg, pending_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [COUNT_W-1:0]   beeps_reg,   beeps_next;
    logic [FREQ_W-1:0]    freq_reg,    freq_next;
    logic [TIME_W-1:0]    on_reg,      on_next;
    logic [TIME_W-1:0]    off_reg,     off_next;
    logic [FREQ_W-1:0]    tone_reg,    tone_next;

    logic [ELAPSED_W-1:0] sum;
    logic [TIME_W:0]      period;
    logic [ELAPSED_W-1:0] wrapped;

    assign sum      = elapsed_reg + {{(ELAPSED_W - TICK_W){1'b0}}, tick_period};
    assign period   = {1'b0, on_reg} + {1'b0, off_reg};
    assign wrapped  = sum - {{(ELAPSED_W - TIME_W - 1){1'b0}}, period};

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        pending_next = pending_reg;
        elapsed_next = elapsed_reg;
        beeps_next   = beeps_reg;
        freq_next    = freq_reg;
        on_next      = on_reg;
        off_next     = off_reg;
        tone_next    = tone_reg;
        if (fire)
        begin
            if (item.kind == KIND_COMMAND)
            begin
                freq_next    = item.tone_freq;
                on_next      = item.on_ms;
                off_next     = item.off_ms;
                beeps_next   = item.repeat_count;
                pending_next = 1'b1;
            end
            else if (pending_reg)
            begin
                pending_next = 1'b0;
                if ((on_reg != '0) && (freq_reg != '0))
                begin
                    tone_next = freq_reg;
                    if (off_reg != '0)
                    begin
                        elapsed_next = '0;
                        phase_next   = PH_SOUND;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                else
                begin
                    tone_next  = '0;
                    phase_next = PH_IDLE;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_SOUND:
                    begin
                        elapsed_next = sum;
                        if (sum >= {{(ELAPSED_W - TIME_W){1'b0}}, on_reg})
                        begin
                            tone_next  = '0;
                            phase_next = PH_GAP;
                        end
                    end
                    PH_GAP:
                    begin
                        elapsed_next = sum;
                        if (sum >= {{(ELAPSED_W - TIME_W - 1){1'b0}}, period})
                        begin
                            elapsed_next = wrapped;
                            if (beeps_reg == COUNT_W'(1))
                            begin
                                tone_next  = '0;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                tone_next  = freq_reg;
                                phase_next = PH_SOUND;
                                if (beeps_reg != '0)
                                begin
                                    beeps_next = beeps_reg - COUNT_W'(1);
                                end
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // outputs: a result only when the driven tone changes
    always_comb
    begin
        res.valid = fire && (item.kind == KIND_TICK) && (tone_next != tone_reg);
        res.tone  = tone_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            pending_reg <= 1'b0;
            elapsed_reg <= '0;
            beeps_reg   <= '0;
            freq_reg    <= '0;
            on_reg      <= '0;
            off_reg     <= '0;
            tone_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
            elapsed_reg <= elapsed_next;
            beeps_reg   <= beeps_next;
            freq_reg    <= freq_next;
            on_reg      <= on_next;
            off_reg     <= off_next;
            tone_reg    <= tone_next;
        end
    end

    a_sound_drives_tone: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SOUND && !pending_reg) |-> (tone_reg != '0))
        else $error("sounding phase with silent tone");

    a_sound_has_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SOUND && !pending_reg) |-> (off_reg != '0))
        else $error("beeping pattern without off time");

    a_gap_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_GAP && !pending_reg) |-> (tone_reg == '0))
        else $error("gap phase with tone driven");

endmodule

### rtl/bbps_out_reg.sv
// ----------------------------------------------------------------------------
// bbps_out_reg
// Result register: holds a tone change until the receiver takes it.
// ----------------------------------------------------------------------------
module bbps_out_reg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bbps_pkg::result_t               res,
    output logic                            space,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bbps_pkg::FREQ_W-1:0]     tone_out
);
    import bbps_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [FREQ_W-1:0] tone_reg;

    assign space      = !valid_reg || out_ready;
    assign valid_next = res.valid || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            tone_reg <= res.tone;
        end
    end

    assign out_valid = valid_reg;
    assign tone_out  = tone_reg;

endmodule

### rtl/buzzer_beep_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// buzzer_beep_pattern_sequencer
// Beep pattern sequencer: turns command and tick requests into tone changes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one request per accept. kind = 0 is a
//   command that latches tone_freq, on_ms, off_ms and repeat_count and marks
//   the pattern pending; kind = 1 is a tick that advances time by
//   tick_period_ms and ignores the other fields.
//   Output channel (out_valid/out_ready): tone_out carries the new buzzer
//   frequency, 0 for silent, and appears only when the driven tone changes.
//   Configuration channel (cfg_valid/cfg_ready): writes tick_period_ms; it is
//   always ready and should be used while no request is in flight.
//   A request is registered in the input register on accept, taken by the
//   core once the output register has space and written to the output
//   register, which drives tone_out.
//   Throughput: one request per cycle while the output register has space;
//   the state update is combinational (one 18-bit add, compare and subtract).
//   Reset: pattern idle, nothing pending, tone silent, tick period 30 ms.
//   Stall: while the output register is full and not taken, the core holds
//   and the input register fills; in_ready then drops until space returns.
// ----------------------------------------------------------------------------
module buzzer_beep_pattern_sequencer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             kind,
    input  logic [bbps_pkg::FREQ_W-1:0]      tone_freq,
    input  logic [bbps_pkg::TIME_W-1:0]      on_ms,
    input  logic [bbps_pkg::TIME_W-1:0]      off_ms,
    input  logic [bbps_pkg::COUNT_W-1:0]     repeat_count,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [bbps_pkg::FREQ_W-1:0]      tone_out,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bbps_pkg::TICK_W-1:0]      tick_period_ms
);
    import bbps_pkg::*;

    item_t             in_item;
    item_t             item;
    logic              item_valid;
    logic              space;
    logic              fire;
    result_t           res;
    logic [TICK_W-1:0] tick_period_reg;

    // gather the request fields
    assign in_item.kind         = kind;
    assign in_item.tone_freq    = tone_freq;
    assign in_item.on_ms        = on_ms;
    assign in_item.off_ms       = off_ms;
    assign in_item.repeat_count = repeat_count;

    // configuration: take every write at once
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_period_reg <= TICK_PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tick_period_reg <= tick_period_ms;
        end
    end

    // advance a held request only when the result register can take it
    assign fire = item_valid && space;

    bbps_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    bbps_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .item        (item),
        .tick_period (tick_period_reg),
        .res         (res)
    );

    bbps_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tone_out  (tone_out)
    );

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the buzzer beep pattern sequencer. Command and tick
// requests are streamed in from a queue with random gaps on both channels.
// Every accepted request runs through a local model of the pattern timer, and
// each tone change the block emits is matched in order against that model.
// The tick period is rewritten between phases, including 0, 1, 1000 and 1023.
// ----------------------------------------------------------------------------
module tb_top;

    import bbps_pkg::*;

    // Generous ceiling on the whole run, in clock cycles.
    localparam int unsigned CYCLE_LIMIT  = 200000;
    // Margin for the block to drain from accept to tone_out.
    localparam int unsigned DRAIN_CYCLES = 8;
    // Chance out of a hundred that a side idles in a given cycle.
    localparam int unsigned IDLE_PCT     = 19;
    localparam int unsigned RANDOM_PER_PHASE = 190;

    // One expected tone change, stamped with the time it was predicted.
    typedef struct {
        logic [FREQ_W-1:0] tone;
        longint unsigned   stamp;
    } tone_change_t;

    // ------------------------------------------------------------------
    // Signals to and from the block, all known from time zero
    // ------------------------------------------------------------------
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 kind = KIND_TICK;
    logic [FREQ_W-1:0]    tone_freq = '0;
    logic [TIME_W-1:0]    on_ms = '0;
    logic [TIME_W-1:0]    off_ms = '0;
    logic [COUNT_W-1:0]   repeat_count = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [FREQ_W-1:0]    tone_out;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [TICK_W-1:0]    cfg_tick_ms = TICK_PERIOD_RESET;

    // ------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------
    item_t                request_q[$];     // requests still to be offered
    item_t                bus_item;         // request currently on the bus
    tone_change_t         tone_changes_q[$];
    logic                 calm = 1'b0;      // set: neither side idles
    int unsigned          queued_total = 0;
    int unsigned          commands_sent = 0;
    int unsigned          ticks_sent = 0;
    int unsigned          tones_checked = 0;
    int unsigned          cfg_writes = 0;
    int unsigned          errors = 0;
    int unsigned          cycle_count = 0;

    logic [TICK_W-1:0]    period_plan [7] = '{10'd1, 10'd1023, 10'd0, 10'd1000,
                                              10'd30, 10'd7, 10'd250};

    // ------------------------------------------------------------------
    // Local copy of the pattern state, at reset values
    // ------------------------------------------------------------------
    logic [TICK_W-1:0]    tick_ms = TICK_PERIOD_RESET;
    phase_t               pat_phase = PH_IDLE;
    logic                 pat_pending = 1'b0;
    logic [ELAPSED_W-1:0] elapsed = '0;
    logic [COUNT_W-1:0]   beeps_left = '0;
    logic [FREQ_W-1:0]    held_freq = '0;
    logic [TIME_W-1:0]    held_on = '0;
    logic [TIME_W-1:0]    held_off = '0;
    logic [FREQ_W-1:0]    tone_now = '0;

    buzzer_beep_pattern_sequencer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .tone_freq      (tone_freq),
        .on_ms          (on_ms),
        .off_ms         (off_ms),
        .repeat_count   (repeat_count),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .tone_out       (tone_out),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .tick_period_ms (cfg_tick_ms)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Pattern timer model: apply one request, return 1 when the tone moves
    // ------------------------------------------------------------------
    function automatic logic advance_pattern(input item_t req,
                                             output logic [FREQ_W-1:0] tone);
        logic [FREQ_W-1:0] next_tone;
        logic [TIME_W:0]   full_period;
        logic              moved;
        next_tone   = tone_now;
        full_period = {1'b0, held_on} + {1'b0, held_off};
        moved       = 1'b0;
        if (req.kind == KIND_COMMAND) begin
            // Latch only; the running pattern carries on until the next tick.
            held_freq   = req.tone_freq;
            held_on     = req.on_ms;
            held_off    = req.off_ms;
            beeps_left  = req.repeat_count;
            pat_pending = 1'b1;
        end else begin
            if (pat_pending) begin
                // First tick after a command restarts the pattern on the spot.
                pat_pending = 1'b0;
                if (held_on != '0 && held_freq != '0) begin
                    next_tone = held_freq;
                    if (held_off != '0) begin
                        elapsed   = '0;
                        pat_phase = PH_SOUND;
                    end else begin
                        // No gap: hold the tone continuously.
                        pat_phase = PH_IDLE;
                    end
                end else begin
                    next_tone = '0;
                    pat_phase = PH_IDLE;
                end
            end else if (pat_phase == PH_SOUND) begin
                elapsed = elapsed + tick_ms;
                if (elapsed >= held_on) begin
                    next_tone = '0;
                    pat_phase = PH_GAP;
                end
            end else if (pat_phase == PH_GAP) begin
                elapsed = elapsed + tick_ms;
                if (elapsed >= full_period) begin
                    // Wrap by the full period rather than clearing.
                    elapsed = elapsed - full_period;
                    if (beeps_left == COUNT_W'(1)) begin
                        next_tone = '0;
                        pat_phase = PH_IDLE;
                    end else begin
                        // A count of zero never runs down.
                        next_tone = held_freq;
                        if (beeps_left != '0)
                            beeps_left = beeps_left - 1'b1;
                        pat_phase = PH_SOUND;
                    end
                end
            end
            if (next_tone != tone_now) begin
                tone_now = next_tone;
                moved    = 1'b1;
            end
        end
        tone = tone_now;
        return moved;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Request queue helpers
    // ------------------------------------------------------------------
    task automatic queue_command(input logic [FREQ_W-1:0] f,
                                 input logic [TIME_W-1:0] t_on,
                                 input logic [TIME_W-1:0] t_off,
                                 input logic [COUNT_W-1:0] reps);
        item_t req;
        req.kind         = KIND_COMMAND;
        req.tone_freq    = f;
        req.on_ms        = t_on;
        req.off_ms       = t_off;
        req.repeat_count = reps;
        request_q.push_back(req);
        queued_total++;
    endtask

    // Ticks carry random junk in the unused fields to show it is ignored.
    task automatic queue_tick();
        item_t req;
        req.kind         = KIND_TICK;
        req.tone_freq    = FREQ_W'($urandom);
        req.on_ms        = TIME_W'($urandom);
        req.off_ms       = TIME_W'($urandom);
        req.repeat_count = COUNT_W'($urandom);
        request_q.push_back(req);
        queued_total++;
    endtask

    // Durations scaled to the tick period so that patterns actually turn over,
    // with zero, tiny and full-range values mixed in.
    function automatic logic [TIME_W-1:0] pick_time();
        int unsigned span;
        int unsigned r;
        span = (tick_ms == '0) ? 4 : 4 * tick_ms;
        r    = $urandom_range(19);
        if (r < 2)
            return '0;
        else if (r < 14)
            return TIME_W'($urandom_range(span, 1));
        else if (r < 17)
            return TIME_W'($urandom);
        else
            return TIME_W'($urandom_range(3, 1));
    endfunction

    // ------------------------------------------------------------------
    // Random phase: mostly command-then-ticks patterns, some noise and
    // some patterns cut short by a fresh command
    // ------------------------------------------------------------------
    task automatic run_random(input int unsigned n_items);
        int unsigned      start;
        int unsigned      r;
        logic [FREQ_W-1:0] f;
        logic [COUNT_W-1:0] reps;
        start = queued_total;
        while (queued_total - start < n_items) begin
            r = $urandom_range(99);
            if (r < 75) begin
                f = ($urandom_range(9) == 0) ? '0 : FREQ_W'($urandom_range(65535, 1));
                r = $urandom_range(99);
                if (r < 25)
                    reps = '0;
                else if (r < 50)
                    reps = COUNT_W'(1);
                else if (r < 80)
                    reps = COUNT_W'($urandom_range(5, 2));
                else
                    reps = COUNT_W'($urandom);
                queue_command(f, pick_time(), pick_time(), reps);
                repeat ($urandom_range(40, 4)) queue_tick();
            end else if (r < 88) begin
                if ($urandom_range(1) == 0)
                    queue_tick();
                else
                    queue_command(FREQ_W'($urandom), TIME_W'($urandom),
                                  TIME_W'($urandom), COUNT_W'($urandom));
            end else begin
                queue_command(FREQ_W'($urandom), pick_time(), pick_time(),
                              COUNT_W'($urandom_range(3)));
                if ($urandom_range(1) == 0)
                    queue_command(FREQ_W'($urandom), pick_time(), pick_time(),
                                  COUNT_W'($urandom_range(3)));
                repeat ($urandom_range(2)) queue_tick();
            end
        end
    endtask

    // Hold until every queued request is in and every tone change is out,
    // then let the pipeline drain, since commands leave nothing to wait for.
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (request_q.size() != 0 || in_valid || tone_changes_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write the tick period while the block is idle; the model follows on accept.
    task automatic write_tick_period(input logic [TICK_W-1:0] period);
        @(posedge clk);
        cfg_valid   <= 1'b1;
        cfg_tick_ms <= period;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tick_ms    = period;
        cfg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Request driver: predict on accept, then offer the next request or drop
    // valid. Valid and payload hold while the block stalls.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : drive_requests
        logic [FREQ_W-1:0] predicted;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                if (bus_item.kind == KIND_COMMAND)
                    commands_sent++;
                else
                    ticks_sent++;
                if (advance_pattern(bus_item, predicted))
                    tone_changes_q.push_back('{tone: predicted, stamp: $time});
            end
            if (!in_valid || in_ready) begin
                if (request_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    bus_item      = request_q.pop_front();
                    in_valid     <= 1'b1;
                    kind         <= bus_item.kind;
                    tone_freq    <= bus_item.tone_freq;
                    on_ms        <= bus_item.on_ms;
                    off_ms       <= bus_item.off_ms;
                    repeat_count <= bus_item.repeat_count;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure: drop ready at random outside the calm stretch.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Tone monitor: match each accepted tone change against the oldest
    // prediction. A prediction stamped in this very step cannot be the
    // source of a result already sitting in the output register.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : check_tones
        tone_change_t head;
        if (rst_n && out_valid && out_ready) begin
            if (tone_changes_q.size() == 0 || tone_changes_q[0].stamp == $time) begin
                report_mismatch($sformatf("tone %0d with no change pending", tone_out));
            end else begin
                head = tone_changes_q.pop_front();
                if (tone_out !== head.tone)
                    report_mismatch($sformatf("tone_out %0d, predicted %0d",
                                              tone_out, head.tone));
                tones_checked++;
            end
        end
    end

    // Watchdog on the cycle count.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[%0t] timeout after %0d cycles", $time, cycle_count);
        $display("buzzer_beep_pattern_sequencer verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : run_test
        // Hold reset from time zero, release on a rising edge.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, at the reset tick period of 30 ms.
        queue_tick();                                       // idle tick, silent
        // Two beeps of 60 on / 30 off, the second ending the pattern.
        queue_command(16'hFFFF, 16'd60, 16'd30, 16'd2);
        repeat (7) queue_tick();
        // Zero frequency silences.
        queue_command(16'h0000, 16'd100, 16'd100, 16'd3);
        queue_tick();
        // Zero on time silences.
        queue_command(16'd1234, 16'h0000, 16'd50, 16'd1);
        queue_tick();
        // Zero off time sounds continuously.
        queue_command(16'd500, 16'd10, 16'h0000, 16'h0000);
        repeat (2) queue_tick();
        // Longest on and off times, single beep.
        queue_command(16'h0001, 16'hFFFF, 16'hFFFF, 16'h0001);
        queue_tick();
        // All fields at zero.
        queue_command(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_tick();
        // Repeat forever, then a command overwritten before its tick.
        queue_command(16'h8000, 16'd30, 16'd30, 16'h0000);
        repeat (6) queue_tick();
        queue_command(16'h00FF, 16'd40, 16'd20, 16'hFFFF);
        queue_command(16'h7F00, 16'd90, 16'd60, 16'd1);
        repeat (8) queue_tick();
        wait_quiet();

        // Random phases, one per tick period, with one calm stretch.
        foreach (period_plan[i]) begin
            write_tick_period(period_plan[i]);
            @(negedge clk);
            calm = (i == 3);
            run_random(RANDOM_PER_PHASE);
            wait_quiet();
        end
        calm = 1'b0;

        if (tone_changes_q.size() != 0)
            report_mismatch($sformatf("%0d tone changes never arrived",
                                      tone_changes_q.size()));

        $display("Ran %0d commands and %0d ticks through %0d tick-period writes,",
                 commands_sent, ticks_sent, cfg_writes);
        $display("checking %0d tone changes in %0d cycles.", tones_checked, cycle_count);
        if (errors == 0)
            $display("buzzer_beep_pattern_sequencer verification clean");
        else
            $display("buzzer_beep_pattern_sequencer verification failed");
        $finish;
    end

endmodule

### buzzer_beep_pattern_sequencer.f
rtl/bbps_pkg.sv
rtl/bbps_in_reg.sv
rtl/bbps_core.sv
rtl/bbps_out_reg.sv
rtl/buzzer_beep_pattern_sequencer.sv
sim/tb_top.sv
